>>> src/pff_pkg.sv
// ----------------------------------------------------------------------------
// pff_pkg: shared definitions for the page frame free list
// Sizes, register and command codes, payload types and the microcode ROM.
// ----------------------------------------------------------------------------
package pff_pkg;

   localparam int NUM_PAGES  = 1024;
   localparam int PAGE_BYTES = 4096;
   localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
   localparam int IDX_W      = $clog2(NUM_PAGES);
   localparam int LINK_W     = IDX_W + 1;
   localparam int ADDR_W     = 32;
   localparam int PAGE_NUM_W = ADDR_W - PAGE_SHIFT;

   // The link code one past the last page index marks the end of the list.
   localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(NUM_PAGES);

   localparam logic [ADDR_W-1:0] REGION_START_RESET = 32'h8000_0000;
   localparam logic [ADDR_W-1:0] REGION_STOP_RESET  = 32'h8800_0000;

   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_REGION_START = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REGION_STOP  = 1'd1;

   localparam logic [1:0] CMD_INIT  = 2'd0;
   localparam logic [1:0] CMD_ALLOC = 2'd1;
   localparam logic [1:0] CMD_FREE  = 2'd2;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_BAD   = 2'd2;

   typedef struct packed {
      logic [1:0]        command;
      logic [ADDR_W-1:0] page_address;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] granted_address;
      logic [1:0]        status;
   } rsp_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_INIT_START,
      OP_INIT_PUSH,
      OP_ALLOC_READ,
      OP_ALLOC_POP,
      OP_FREE_CALC,
      OP_FREE_PUSH,
      OP_EMIT
   } op_type;

   typedef enum logic [2:0] {
      COND_NEVER,
      COND_ACCEPT,
      COND_BASE_OVF,
      COND_INIT_END,
      COND_HEAD_NULL,
      COND_FREE_BAD,
      COND_OUT_BUSY
   } cond_type;

   typedef enum logic [2:0] {
      STEP_IDLE,
      STEP_INIT_START,
      STEP_INIT_LOOP,
      STEP_ALLOC_CHK,
      STEP_ALLOC_POP,
      STEP_FREE_CALC,
      STEP_FREE_PUSH,
      STEP_RESP
   } step_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type tgt_t;
      step_type tgt_f;
   } uword_type;

   // Condition inputs from the datapath to the sequencer.
   typedef struct packed {
      logic req_valid;
      logic base_ovf;
      logic init_end;
      logic head_null;
      logic free_bad;
      logic out_busy;
   } flags_type;

   // Control from the sequencer to the datapath.
   typedef struct packed {
      op_type op;
      logic   hit;
      logic   req_ready;
   } ctrl_type;

   // Rounds a region start up to the next page boundary; bit 32 set means
   // the rounded base no longer fits in 32 bits.
   function automatic logic [ADDR_W:0] round_base(input logic [ADDR_W-1:0] start);
      logic [ADDR_W:0] sum;
      sum = {1'b0, start} + (ADDR_W+1)'(PAGE_BYTES - 1);
      return sum & ~((ADDR_W+1)'(PAGE_BYTES - 1));
   endfunction

   // Microcode ROM. When the step's condition holds the sequencer goes to
   // tgt_t, otherwise to tgt_f. The accept condition dispatches on the command.
   function automatic uword_type ucode(input step_type s);
      uword_type w;
      unique case (s)
         STEP_IDLE:       w = '{OP_NONE,       COND_ACCEPT,    STEP_IDLE, STEP_IDLE};
         STEP_INIT_START: w = '{OP_INIT_START, COND_BASE_OVF,  STEP_RESP, STEP_INIT_LOOP};
         STEP_INIT_LOOP:  w = '{OP_INIT_PUSH,  COND_INIT_END,  STEP_RESP, STEP_INIT_LOOP};
         STEP_ALLOC_CHK:  w = '{OP_ALLOC_READ, COND_HEAD_NULL, STEP_RESP, STEP_ALLOC_POP};
         STEP_ALLOC_POP:  w = '{OP_ALLOC_POP,  COND_NEVER,     STEP_RESP, STEP_RESP};
         STEP_FREE_CALC:  w = '{OP_FREE_CALC,  COND_NEVER,     STEP_FREE_PUSH, STEP_FREE_PUSH};
         STEP_FREE_PUSH:  w = '{OP_FREE_PUSH,  COND_FREE_BAD,  STEP_RESP, STEP_RESP};
         STEP_RESP:       w = '{OP_EMIT,       COND_OUT_BUSY,  STEP_RESP, STEP_IDLE};
         default:         w = '{OP_NONE,       COND_NEVER,     STEP_IDLE, STEP_IDLE};
      endcase
      return w;
   endfunction

endpackage

>>> src/page_frame_free_list_top.sv
// ----------------------------------------------------------------------------
// page_frame_free_list_top: LIFO allocator of fixed-size physical pages
// Link memory, head register, region registers and the result register.
// ----------------------------------------------------------------------------
// The block takes one command at a time and works it in microcode steps. A
// successful allocate and any free pass a check step (head or address), a
// pop or push step around the registered read of the link memory, and the
// result step, which loads the result into the output register. An allocate
// from an empty list goes from the head check to the result step, and an
// unused command code goes there from idle. Init clears the head and pushes
// the pages, writing the link memory one page per cycle, then takes the
// result step; when the rounded region start does not fit in 32 bits it goes
// from the start step straight to the result step. The result step holds
// while the previous result still waits on the output. The next command is
// taken in the cycle after the result is loaded, even while that result still
// waits on the output. There is no clearing pass after reset: the list starts
// empty and links are only read for pages that were pushed.
module page_frame_free_list_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  pff_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output pff_pkg::rsp_type                  rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [pff_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pff_pkg::ADDR_W-1:0]        csr_wdata
);

   localparam int LW = pff_pkg::LINK_W;
   localparam int IW = pff_pkg::IDX_W;
   localparam int AW = pff_pkg::ADDR_W;

   pff_pkg::flags_type flags;
   pff_pkg::ctrl_type  ctrl;

   logic [AW-1:0]  start_ff;
   logic [AW-1:0]  stop_ff;
   logic [AW:0]    base_ff;
   logic [LW-1:0]  head_ff;
   logic [LW-1:0]  page_cnt_ff;
   logic [AW:0]    page_end_ff;
   logic [AW-1:0]  pa_ff;
   logic           free_ok_ff;
   logic [IW-1:0]  free_idx_ff;
   logic [AW-1:0]  res_addr_ff;
   logic [1:0]     res_status_ff;
   logic           rsp_valid_ff;
   pff_pkg::rsp_type rsp_data_ff;

   logic [AW-1:0]                  pa_diff;
   logic [pff_pkg::PAGE_NUM_W-1:0] pa_page;
   logic                           free_ok;
   logic                           req_xfer;
   logic                           emit;
   logic                           ram_we;
   logic [IW-1:0]                  ram_waddr;
   logic [LW-1:0]                  ram_rdata;

   pff_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .flags   (flags),
      .command (req_data.command),
      .ctrl    (ctrl)
   );

   pff_ram #(
      .WIDTH (LW),
      .DEPTH (pff_pkg::NUM_PAGES)
   ) u_link_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (head_ff),
      .raddr (head_ff[IW-1:0]),
      .rdata (ram_rdata)
   );

   assign req_ready = ctrl.req_ready;
   assign req_xfer  = req_valid && ctrl.req_ready;
   assign csr_ready = 1'b1;
   assign emit      = (ctrl.op == pff_pkg::OP_EMIT) && !ctrl.hit;

   assign flags.req_valid = req_valid;
   assign flags.base_ovf  = base_ff[AW];
   assign flags.init_end  = (page_cnt_ff == LW'(pff_pkg::NUM_PAGES))
                            || (page_end_ff > {1'b0, stop_ff});
   assign flags.head_null = (head_ff == pff_pkg::LINK_NULL);
   assign flags.free_bad  = !free_ok_ff;
   assign flags.out_busy  = rsp_valid_ff && !rsp_ready;

   // Free address checks: page aligned, inside the region, at or above the
   // rounded base and within the managed page count.
   assign pa_diff = pa_ff - base_ff[AW-1:0];
   assign pa_page = pa_diff[AW-1:pff_pkg::PAGE_SHIFT];
   assign free_ok = (pa_ff[pff_pkg::PAGE_SHIFT-1:0] == '0)
                    && (pa_ff >= start_ff)
                    && (pa_ff < stop_ff)
                    && ({1'b0, pa_ff} >= base_ff)
                    && ((AW+1)'(pa_page) < (AW+1)'(pff_pkg::NUM_PAGES));

   assign ram_we = !ctrl.hit && (ctrl.op == pff_pkg::OP_INIT_PUSH
                                 || ctrl.op == pff_pkg::OP_FREE_PUSH);
   assign ram_waddr = (ctrl.op == pff_pkg::OP_INIT_PUSH) ? page_cnt_ff[IW-1:0]
                                                         : free_idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= pff_pkg::REGION_START_RESET;
         stop_ff  <= pff_pkg::REGION_STOP_RESET;
         base_ff  <= pff_pkg::round_base(pff_pkg::REGION_START_RESET);
      end else if (csr_valid) begin
         unique case (csr_index)
            pff_pkg::CSR_REGION_START: begin
               start_ff <= csr_wdata;
               base_ff  <= pff_pkg::round_base(csr_wdata);
            end
            pff_pkg::CSR_REGION_STOP: begin
               stop_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= pff_pkg::LINK_NULL;
      end else begin
         case (ctrl.op)
            pff_pkg::OP_INIT_START: head_ff <= pff_pkg::LINK_NULL;
            pff_pkg::OP_INIT_PUSH: begin
               if (!ctrl.hit) begin
                  head_ff <= page_cnt_ff;
               end
            end
            pff_pkg::OP_ALLOC_POP: head_ff <= ram_rdata;
            pff_pkg::OP_FREE_PUSH: begin
               if (!ctrl.hit) begin
                  head_ff <= {1'b0, free_idx_ff};
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         pa_ff         <= req_data.page_address;
         res_addr_ff   <= '0;
         res_status_ff <= pff_pkg::STATUS_OK;
      end
      case (ctrl.op)
         pff_pkg::OP_INIT_START: begin
            page_cnt_ff <= '0;
            page_end_ff <= base_ff + (AW+1)'(pff_pkg::PAGE_BYTES);
         end
         pff_pkg::OP_INIT_PUSH: begin
            if (!ctrl.hit) begin
               page_cnt_ff <= page_cnt_ff + LW'(1);
               page_end_ff <= page_end_ff + (AW+1)'(pff_pkg::PAGE_BYTES);
            end
         end
         pff_pkg::OP_ALLOC_READ: begin
            if (ctrl.hit) begin
               res_status_ff <= pff_pkg::STATUS_EMPTY;
            end else begin
               res_addr_ff <= base_ff[AW-1:0]
                              + (AW'(head_ff[IW-1:0]) << pff_pkg::PAGE_SHIFT);
            end
         end
         pff_pkg::OP_FREE_CALC: begin
            free_ok_ff  <= free_ok;
            free_idx_ff <= pa_page[IW-1:0];
         end
         pff_pkg::OP_FREE_PUSH: begin
            if (ctrl.hit) begin
               res_status_ff <= pff_pkg::STATUS_BAD;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_data_ff.granted_address <= res_addr_ff;
         rsp_data_ff.status          <= res_status_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> src/pff_ram.sv
// ----------------------------------------------------------------------------
// pff_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; contents undefined at reset.
// ----------------------------------------------------------------------------
module pff_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> src/pff_seq.sv
// ----------------------------------------------------------------------------
// pff_seq: microcode sequencer for the page frame free list
// Step counter, control ROM lookup, condition select and jump logic.
// ----------------------------------------------------------------------------
module pff_seq (
   input  logic                clock,
   input  logic                reset,
   input  pff_pkg::flags_type  flags,
   input  logic [1:0]          command,
   output pff_pkg::ctrl_type   ctrl
);

   pff_pkg::step_type  step_ff;
   pff_pkg::step_type  step_in;
   pff_pkg::uword_type uword;
   logic               hit;

   assign uword = pff_pkg::ucode(step_ff);

   always_comb begin
      unique case (uword.cond)
         pff_pkg::COND_NEVER:     hit = 1'b0;
         pff_pkg::COND_ACCEPT:    hit = flags.req_valid;
         pff_pkg::COND_BASE_OVF:  hit = flags.base_ovf;
         pff_pkg::COND_INIT_END:  hit = flags.init_end;
         pff_pkg::COND_HEAD_NULL: hit = flags.head_null;
         pff_pkg::COND_FREE_BAD:  hit = flags.free_bad;
         pff_pkg::COND_OUT_BUSY:  hit = flags.out_busy;
         default:                 hit = 1'b0;
      endcase
   end

   always_comb begin
      if (uword.cond == pff_pkg::COND_ACCEPT && hit) begin
         // Unused command codes go straight to the result step.
         case (command)
            pff_pkg::CMD_INIT:  step_in = pff_pkg::STEP_INIT_START;
            pff_pkg::CMD_ALLOC: step_in = pff_pkg::STEP_ALLOC_CHK;
            pff_pkg::CMD_FREE:  step_in = pff_pkg::STEP_FREE_CALC;
            default:            step_in = pff_pkg::STEP_RESP;
         endcase
      end else if (hit) begin
         step_in = uword.tgt_t;
      end else begin
         step_in = uword.tgt_f;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= pff_pkg::STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

   assign ctrl.op        = uword.op;
   assign ctrl.hit       = hit;
   assign ctrl.req_ready = (uword.cond == pff_pkg::COND_ACCEPT);

endmodule

>>> src/pff_checker.sv
// ----------------------------------------------------------------------------
// pff_checker: port-level checks for the page frame free list
// Watches the request and result channels of the top level over time.
// ----------------------------------------------------------------------------
module pff_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input pff_pkg::rsp_type rsp_data
);

   // A result that is not taken stays on the output unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed or dropped before its transfer");

   // Empty and rejected results never carry an address.
   a_no_grant_on_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != pff_pkg::STATUS_OK
      |-> rsp_data.granted_address == '0)
      else $error("error result carries a granted address");

   // Commands are worked one at a time, so a transfer closes the request side.
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while a command is in progress");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind page_frame_free_list_top pff_checker u_pff_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

>>> tb/free_list_checker.sv
// ----------------------------------------------------------------------------
// free_list_checker: result checker for the page frame free list
// Tracks register writes and accepted commands on the ports, keeps its own
// copy of the head and link words, and compares every result transfer with
// the oldest predicted grant.
// ----------------------------------------------------------------------------
module free_list_checker
   import pff_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  req_type              req_data,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  rsp_type              rsp_data,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [ADDR_W-1:0]    csr_wdata,
   output int                   fail_count,
   output int                   outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [ADDR_W-1:0] start_reg;
   logic [ADDR_W-1:0] stop_reg;
   logic [LINK_W-1:0] head_idx;
   logic [LINK_W-1:0] link_mem [NUM_PAGES];
   rsp_type           expected_grants [$];
   int                miss_total = 0;
   int                pending_total = 0;

   assign fail_count  = miss_total;
   assign outstanding = pending_total;

   // Region start rounded up to a page boundary; bit 32 flags overflow.
   function automatic logic [ADDR_W:0] page_base(input logic [ADDR_W-1:0] start);
      logic [ADDR_W:0] sum;
      sum = {1'b0, start} + (ADDR_W+1)'(PAGE_BYTES - 1);
      return {sum[ADDR_W:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
   endfunction

   task automatic run_command(input req_type cmd_in, output rsp_type res);
      logic [ADDR_W:0]   base;
      logic [ADDR_W+1:0] page_end;
      logic [ADDR_W:0]   offset;
      logic [ADDR_W-1:0] pa;
      int unsigned       k;
      base = page_base(start_reg);
      pa = cmd_in.page_address;
      res.granted_address = '0;
      res.status = STATUS_OK;
      case (cmd_in.command)
         CMD_INIT: begin
            head_idx = LINK_NULL;
            if (!base[ADDR_W]) begin
               for (k = 0; k < NUM_PAGES; k++) begin
                  page_end = (ADDR_W+2)'(base) + (ADDR_W+2)'(k + 1) * (ADDR_W+2)'(PAGE_BYTES);
                  if (page_end > (ADDR_W+2)'(stop_reg))
                     break;
                  link_mem[k] = head_idx;
                  head_idx = LINK_W'(k);
               end
            end
         end
         CMD_ALLOC: begin
            if (head_idx >= LINK_NULL) begin
               res.status = STATUS_EMPTY;
            end else begin
               // The address follows the current region start, even if it
               // changed after the page was pushed.
               res.granted_address = ADDR_W'(base + (ADDR_W+1)'(head_idx) *
                                             (ADDR_W+1)'(PAGE_BYTES));
               head_idx = link_mem[head_idx[IDX_W-1:0]];
            end
         end
         CMD_FREE: begin
            if (pa[PAGE_SHIFT-1:0] != '0 || pa < start_reg || pa >= stop_reg ||
                {1'b0, pa} < base) begin
               res.status = STATUS_BAD;
            end else begin
               offset = {1'b0, pa} - base;
               if (offset[ADDR_W:PAGE_SHIFT] >= NUM_PAGES) begin
                  res.status = STATUS_BAD;
               end else begin
                  link_mem[offset[PAGE_SHIFT+IDX_W-1:PAGE_SHIFT]] = head_idx;
                  head_idx = {1'b0, offset[PAGE_SHIFT+IDX_W-1:PAGE_SHIFT]};
               end
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         start_reg = REGION_START_RESET;
         stop_reg  = REGION_STOP_RESET;
         head_idx  = LINK_NULL;
         expected_grants.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_grants.size() == 0) begin
               if (miss_total < 10)
                  $display("%0t: unexpected result addr %h status %0d", $realtime,
                           rsp_data.granted_address, rsp_data.status);
               miss_total++;
            end else begin
               want = expected_grants.pop_front();
               if (rsp_data.granted_address !== want.granted_address ||
                   rsp_data.status !== want.status) begin
                  if (miss_total < 10)
                     $display("%0t: mismatch, expected addr %h status %0d, got addr %h status %0d",
                              $realtime, want.granted_address, want.status,
                              rsp_data.granted_address, rsp_data.status);
                  miss_total++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_REGION_START: start_reg = csr_wdata;
               CSR_REGION_STOP:  stop_reg  = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            run_command(req_data, want);
            expected_grants.push_back(want);
         end
      end
      pending_total <= expected_grants.size();
   end

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: regression bench for the page frame free list
// Runs directed commands over the region edge cases, then random phases of
// init, allocate, free and spare-code traffic under changing regions, with
// bursty input and a stalling result side, checked by free_list_checker.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import pff_pkg::*;

   localparam logic [1:0] CMD_SPARE   = 2'd3;
   localparam int         ITEM_GOAL   = 1250;
   localparam int         CYCLE_LIMIT = 1_000_000;
   localparam int         HOLD_CYCLES = 300;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   req_type              req_data;
   logic                 rsp_valid;
   logic                 rsp_ready;
   rsp_type              rsp_data;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [ADDR_W-1:0]    csr_wdata;
   int                   fail_count;
   int                   outstanding;

   int                   burst_left = 0;
   int                   item_total = 0;
   int                   cmd_seen [4] = '{0, 0, 0, 0};
   int                   csr_total = 0;
   int                   region_total = 0;
   int                   hold_asked = 0;
   logic [ADDR_W+1:0]    tb_base;
   int unsigned          tb_pages;

   page_frame_free_list_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   free_list_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // After each transfer, either keep valid up for the next command or
   // drop it for a random gap and start a new burst.
   task automatic pace();
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 6);
      end
   endtask

   task automatic send_command(input logic [1:0] cmd, input logic [ADDR_W-1:0] addr);
      req_type item;
      item.command = cmd;
      item.page_address = addr;
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      cmd_seen[cmd]++;
      item_total++;
      pace();
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [ADDR_W-1:0] value);
      drain();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      csr_total++;
   endtask

   // Writes both bounds and keeps the rounded base and page span for
   // picking free addresses.
   task automatic set_region(input logic [ADDR_W-1:0] s, input logic [ADDR_W-1:0] e);
      write_csr(CSR_REGION_START, s);
      write_csr(CSR_REGION_STOP, e);
      tb_base = ((ADDR_W+2)'(s) + (ADDR_W+2)'(PAGE_BYTES - 1)) &
                ~(ADDR_W+2)'(PAGE_BYTES - 1);
      if (tb_base >= (ADDR_W+2)'(e))
         tb_pages = 0;
      else
         tb_pages = int'(((ADDR_W+2)'(e) - tb_base) >> PAGE_SHIFT);
      if (tb_pages > 1100)
         tb_pages = 1100;
      region_total++;
   endtask

   initial begin : rsp_side
      int mode_left;
      int ready_pct;
      int hold_left;
      int hold_served;
      mode_left = 0;
      ready_pct = 100;
      hold_left = 0;
      hold_served = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_served != hold_asked) begin
            hold_served = hold_asked;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               case ($urandom_range(0, 3))
                  0: ready_pct = 100;
                  1: ready_pct = 85;
                  2: ready_pct = 50;
                  default: ready_pct = 10;
               endcase
               mode_left = $urandom_range(5, 60);
            end
            mode_left--;
            rsp_ready <= ($urandom_range(1, 100) <= ready_pct);
         end
      end
   end

   initial begin : watchdog
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Timeout after %0d cycles with %0d results outstanding", CYCLE_LIMIT,
               outstanding);
      $display("Regression FAIL");
      $finish;
   end

   initial begin : stimulus
      int                phase;
      int                n;
      int                pick;
      logic [ADDR_W-1:0] s;
      logic [ADDR_W-1:0] e;
      logic [ADDR_W-1:0] addr;
      logic [ADDR_W+1:0] b;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      csr_valid <= 1'b0;
      csr_index <= CSR_REGION_START;
      csr_wdata <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset region: empty allocate, free and reuse, spare code, bad frees.
      send_command(CMD_ALLOC, 32'h0000_0000);
      send_command(CMD_FREE,  32'h8000_0000);
      send_command(CMD_ALLOC, 32'hFFFF_FFFF);
      send_command(CMD_SPARE, 32'h8000_1000);
      send_command(CMD_FREE,  32'h8000_0004);
      send_command(CMD_FREE,  32'h7FFF_F000);
      send_command(CMD_FREE,  32'h8800_0000);
      send_command(CMD_FREE,  32'h8040_0000);
      // Full list of capacity pages, then a double free of the bottom page.
      send_command(CMD_INIT,  32'h0000_0000);
      send_command(CMD_ALLOC, 32'h0000_0000);
      send_command(CMD_FREE,  32'h8000_0000);
      send_command(CMD_ALLOC, 32'h0000_0000);

      // Unaligned start with two pages; a double free of the head page
      // links it to itself, so allocate keeps returning it.
      set_region(32'h0000_0001, 32'h0000_3000);
      send_command(CMD_INIT,  32'h0000_0000);
      send_command(CMD_FREE,  32'h0000_2000);
      send_command(CMD_ALLOC, 32'h0000_0000);
      send_command(CMD_ALLOC, 32'h0000_0000);
      send_command(CMD_FREE,  32'h0000_0000);

      // Start whose rounded base overflows: old pages get new addresses,
      // and init frees nothing.
      set_region(32'hFFFF_F001, 32'h0000_3000);
      send_command(CMD_ALLOC, 32'h0000_0000);
      send_command(CMD_INIT,  32'h0000_0000);
      send_command(CMD_ALLOC, 32'h0000_0000);

      // Top page of the address space: too short for init, but freeable.
      set_region(32'hFFFF_F000, 32'hFFFF_FFFF);
      send_command(CMD_INIT,  32'h0000_0000);
      send_command(CMD_FREE,  32'hFFFF_F000);
      send_command(CMD_ALLOC, 32'h0000_0000);

      set_region(32'h0000_0000, 32'h0000_0000);
      send_command(CMD_INIT,  32'h0000_0000);
      send_command(CMD_FREE,  32'h0000_0000);

      phase = 0;
      while (item_total < ITEM_GOAL) begin
         phase++;
         if (phase == 1 || $urandom_range(0, 3) != 0) begin
            s = $urandom;
            if ($urandom_range(0, 1) == 0)
               s[PAGE_SHIFT-1:0] = '0;
            case ($urandom_range(0, 9))
               6: begin
                  s = $urandom & 32'h7FFF_F000;
                  e = s + ADDR_W'($urandom_range(300, 1100)) * ADDR_W'(PAGE_BYTES);
               end
               7: e = $urandom_range(0, s);
               8: begin
                  case ($urandom_range(0, 3))
                     0: begin s = 32'h0000_0000; e = 32'hFFFF_FFFF; end
                     1: begin s = 32'hFFFF_FFFF; e = 32'hFFFF_FFFF; end
                     2: begin s = 32'hFFFF_F000; e = 32'hFFFF_FFFF; end
                     default: begin s = 32'h0000_0001; e = 32'h0000_2000; end
                  endcase
               end
               default: begin
                  b = ((ADDR_W+2)'(s) + (ADDR_W+2)'(PAGE_BYTES - 1)) &
                      ~(ADDR_W+2)'(PAGE_BYTES - 1);
                  b = b + ((ADDR_W+2)'($urandom_range(0, 24)) << PAGE_SHIFT) +
                      (ADDR_W+2)'($urandom_range(0, PAGE_BYTES - 1));
                  e = (b > (ADDR_W+2)'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : ADDR_W'(b);
               end
            endcase
            set_region(s, e);
         end
         if ($urandom_range(0, 5) != 0)
            send_command(CMD_INIT, $urandom);
         // One long hold-off on the result side while commands keep coming.
         if (phase == 3)
            hold_asked++;
         n = $urandom_range(30, 90);
         repeat (n) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
               send_command(CMD_ALLOC, $urandom);
            end else if (pick < 87) begin
               case ($urandom_range(0, 9))
                  7: addr = $urandom;
                  8: addr = $urandom & 32'hFFFF_F000;
                  9: addr = ADDR_W'(tb_base + ((ADDR_W+2)'($urandom_range(0, tb_pages))
                                               << PAGE_SHIFT)) |
                            ADDR_W'($urandom_range(1, PAGE_BYTES - 1));
                  default: addr = ADDR_W'(tb_base +
                                          ((ADDR_W+2)'($urandom_range(0, tb_pages + 1))
                                           << PAGE_SHIFT));
               endcase
               send_command(CMD_FREE, addr);
            end else if (pick < 94) begin
               send_command(CMD_SPARE, $urandom);
            end else begin
               send_command(CMD_INIT, $urandom);
            end
         end
      end

      drain();
      repeat (20) @(posedge clock);
      $display("Covered %0d commands (%0d init, %0d allocate, %0d free, %0d spare code)",
               item_total, cmd_seen[CMD_INIT], cmd_seen[CMD_ALLOC], cmd_seen[CMD_FREE],
               cmd_seen[CMD_SPARE]);
      $display("over %0d region settings and %0d register writes; %0d failures",
               region_total, csr_total, fail_count);
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

>>> files.f
src/pff_pkg.sv
src/pff_ram.sv
src/pff_seq.sv
src/page_frame_free_list_top.sv
src/pff_checker.sv
tb/free_list_checker.sv
tb/tb_top.sv
